// File: src/nfc_enc_pkg.sv
// types and constants shared by the nfc host frame encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nfc_enc_pkg;

  localparam logic [7:0] PreambleByte  = 8'h00;
  localparam logic [7:0] StartCode1    = 8'h00;
  localparam logic [7:0] StartCode2    = 8'hFF;
  localparam logic [7:0] PostambleByte = 8'h00;
  localparam logic [7:0] DirHostToCtrl = 8'hD4;
  localparam logic [7:0] ErrorByte     = 8'h00;

  localparam logic       FuncStart     = 1'b0;
  localparam logic       FuncPayload   = 1'b1;

  localparam int unsigned IdxW = 4;

  // byte positions within a frame
  localparam logic [IdxW-1:0] IdxPreamble  = 4'd0;
  localparam logic [IdxW-1:0] IdxStart1    = 4'd1;
  localparam logic [IdxW-1:0] IdxStart2    = 4'd2;
  localparam logic [IdxW-1:0] IdxLen       = 4'd3;
  localparam logic [IdxW-1:0] IdxLcs       = 4'd4;
  localparam logic [IdxW-1:0] IdxDir       = 4'd5;
  localparam logic [IdxW-1:0] IdxBody      = 4'd6;
  localparam logic [IdxW-1:0] IdxDcs       = 4'd7;
  localparam logic [IdxW-1:0] IdxPostamble = 4'd8;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic       func;
    logic [7:0] cmd;
    logic [7:0] payload_len;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       error;
  } out_item_t;

  // one classified request for the byte sequencer
  typedef struct packed {
    logic            err;
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] last;
    logic [7:0]      body;
    logic [7:0]      len;
    logic [7:0]      lcs;
    logic [7:0]      dcs;
  } job_t;

endpackage

`default_nettype wire

// File: src/nfc_enc_front.sv
// front end: accepts requests, tracks frame state and checksum, issues jobs
// depends on nfc_enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nfc_enc_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  nfc_enc_pkg::in_item_t in_item_i,
  output logic                 push_o,
  input  wire                  push_ready_i,
  output nfc_enc_pkg::job_t    job_o
);

  logic [7:0] check_sum_q, check_sum_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       frame_open_q, frame_open_d;

  logic       accept;
  logic [7:0] sum_start;
  logic [7:0] sum_next;
  logic [7:0] left_next;
  logic [7:0] len;
  logic       close;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  assign sum_start = nfc_enc_pkg::DirHostToCtrl + in_item_i.cmd;
  assign sum_next  = check_sum_q + in_item_i.data_byte;
  assign left_next = bytes_left_q - 8'd1;
  assign len       = in_item_i.payload_len + 8'd2;

  always_comb begin
    check_sum_d  = check_sum_q;
    bytes_left_d = bytes_left_q;
    frame_open_d = frame_open_q;
    close        = 1'b0;
    job_o        = '0;
    job_o.len    = len;
    job_o.lcs    = 8'd0 - len;
    if (in_item_i.func == nfc_enc_pkg::FuncStart) begin
      close        = (in_item_i.payload_len == 8'd0);
      job_o.first  = nfc_enc_pkg::IdxPreamble;
      job_o.last   = close ? nfc_enc_pkg::IdxPostamble : nfc_enc_pkg::IdxBody;
      job_o.body   = in_item_i.cmd;
      job_o.dcs    = 8'd0 - sum_start;
      frame_open_d = !close;
      bytes_left_d = in_item_i.payload_len;
      check_sum_d  = close ? 8'd0 : sum_start;
    end else if (!frame_open_q) begin
      job_o.err    = 1'b1;
    end else begin
      close        = (left_next == 8'd0);
      job_o.first  = nfc_enc_pkg::IdxBody;
      job_o.last   = close ? nfc_enc_pkg::IdxPostamble : nfc_enc_pkg::IdxBody;
      job_o.body   = in_item_i.data_byte;
      job_o.dcs    = 8'd0 - sum_next;
      frame_open_d = !close;
      bytes_left_d = left_next;
      check_sum_d  = close ? 8'd0 : sum_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_sum_q  <= 8'd0;
      bytes_left_q <= 8'd0;
      frame_open_q <= 1'b0;
    end else if (accept) begin
      check_sum_q  <= check_sum_d;
      bytes_left_q <= bytes_left_d;
      frame_open_q <= frame_open_d;
    end
  end

endmodule

`default_nettype wire

// File: src/nfc_enc_queue.sv
// short job queue between front end and byte sequencer
// depends on nfc_enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nfc_enc_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  output logic              push_ready_o,
  input  nfc_enc_pkg::job_t push_job_i,
  input  wire               pop_i,
  output logic              head_valid_o,
  output nfc_enc_pkg::job_t head_job_o
);

  nfc_enc_pkg::job_t mem_q [nfc_enc_pkg::QueueDepth];

  logic [nfc_enc_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [nfc_enc_pkg::QueueCntW-1:0] count_q;

  assign push_ready_o = (count_q != nfc_enc_pkg::QueueCntW'(nfc_enc_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/nfc_enc_back.sv
// back end: jobs to frame bytes in the output register, one a cycle if not stalled
// depends on nfc_enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nfc_enc_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    head_valid_i,
  input  nfc_enc_pkg::job_t      head_job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output nfc_enc_pkg::out_item_t out_item_o
);

  logic [nfc_enc_pkg::IdxW-1:0] pos_q;
  logic [nfc_enc_pkg::IdxW-1:0] idx;
  logic                         out_valid_q;
  nfc_enc_pkg::out_item_t       out_q, out_d;
  logic                         advance;
  logic                         fire;
  logic                         last;

  assign idx     = head_job_i.first + pos_q;
  assign last    = head_job_i.err || (idx == head_job_i.last);
  assign advance = !out_valid_q || out_ready_i;
  assign fire    = advance && head_valid_i;
  assign pop_o   = fire && last;

  always_comb begin
    out_d = '0;
    if (head_job_i.err) begin
      out_d.out_byte  = nfc_enc_pkg::ErrorByte;
      out_d.frame_end = 1'b1;
      out_d.error     = 1'b1;
    end else begin
      unique case (idx)
        nfc_enc_pkg::IdxPreamble:  out_d.out_byte = nfc_enc_pkg::PreambleByte;
        nfc_enc_pkg::IdxStart1:    out_d.out_byte = nfc_enc_pkg::StartCode1;
        nfc_enc_pkg::IdxStart2:    out_d.out_byte = nfc_enc_pkg::StartCode2;
        nfc_enc_pkg::IdxLen:       out_d.out_byte = head_job_i.len;
        nfc_enc_pkg::IdxLcs:       out_d.out_byte = head_job_i.lcs;
        nfc_enc_pkg::IdxDir:       out_d.out_byte = nfc_enc_pkg::DirHostToCtrl;
        nfc_enc_pkg::IdxBody:      out_d.out_byte = head_job_i.body;
        nfc_enc_pkg::IdxDcs:       out_d.out_byte = head_job_i.dcs;
        nfc_enc_pkg::IdxPostamble: begin
          out_d.out_byte  = nfc_enc_pkg::PostambleByte;
          out_d.frame_end = 1'b1;
        end
        default:                   out_d.out_byte = nfc_enc_pkg::PostambleByte;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      pos_q       <= last ? '0 : pos_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: src/nfc_host_frame_encoder_core.sv
// top level of the nfc host frame encoder: front end, job queue, byte sequencer
// depends on nfc_enc_pkg, nfc_enc_front, nfc_enc_queue, nfc_enc_back
//
// input channel (in_valid_i / in_ready_o / in_item_i): func 0 starts a frame
// with cmd and payload_len, func 1 carries one payload byte. output channel
// (out_valid_o / out_ready_i / out_item_o) delivers the frame one byte per
// transfer: preamble, start codes, len, lcs, direction, command, payload,
// dcs and postamble, with frame_end on the postamble. a payload byte with no
// frame open gives a single result with frame_end and error set.
// a request is taken by the front end and queued as a job; its first byte
// reaches the output through the job queue and the output register. the back
// end sends one byte per cycle while the receiver is ready, so payload requests
// sustain one per cycle then, but the last of a frame adds dcs and postamble; a
// start request holds the sequencer for 7 bytes, or 9 with an empty payload;
// the four-entry queue absorbs requests meanwhile. reset clears the frame state,
// the queue pointers and count and the output valid flag. when the receiver
// stalls the output byte holds, the queue fills and in_ready_o drops once full.
`timescale 1ns / 1ps
`default_nettype none

module nfc_host_frame_encoder_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  nfc_enc_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output nfc_enc_pkg::out_item_t out_item_o
);

  logic              push;
  logic              push_ready;
  logic              pop;
  logic              head_valid;
  nfc_enc_pkg::job_t push_job;
  nfc_enc_pkg::job_t head_job;

  nfc_enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_ready_i(push_ready),
    .job_o       (push_job)
  );

  nfc_enc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_job_o  (head_job)
  );

  nfc_enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: verif/nfc_host_frame_encoder_core_tb.sv
// testbench for nfc_host_frame_encoder_core: directed frames, a long frame,
// output stalls and random frame sequences checked byte by byte against a predictor
// depends on nfc_enc_pkg and the rtl of nfc_host_frame_encoder_core
`timescale 1ns / 1ps

module nfc_host_frame_encoder_core_tb;

  localparam int unsigned StallCycles = 300;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned InItemW     = $bits(nfc_enc_pkg::in_item_t);

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  nfc_enc_pkg::in_item_t  in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  nfc_enc_pkg::out_item_t out_item;

  // predictor state
  logic [7:0] enc_sum = 8'h00;
  logic [7:0] enc_left = 8'h00;
  logic       enc_open = 1'b0;

  nfc_enc_pkg::out_item_t frame_bytes_q[$];
  nfc_enc_pkg::out_item_t want_byte;
  int unsigned            mismatch_count = 0;
  int unsigned            requests_sent = 0;
  bit                     idle_en = 1'b1;
  bit                     rx_hold_req = 1'b0;

  nfc_host_frame_encoder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic nfc_enc_pkg::out_item_t frame_byte(logic [7:0] b, logic fe, logic er);
    nfc_enc_pkg::out_item_t r;
    r.out_byte  = b;
    r.frame_end = fe;
    r.error     = er;
    return r;
  endfunction

  task automatic close_predicted_frame();
    frame_bytes_q.push_back(frame_byte(8'h00 - enc_sum, 1'b0, 1'b0));
    frame_bytes_q.push_back(frame_byte(nfc_enc_pkg::PostambleByte, 1'b1, 1'b0));
    enc_open = 1'b0;
    enc_left = 8'h00;
    enc_sum  = 8'h00;
  endtask

  task automatic predict_frame_bytes(input nfc_enc_pkg::in_item_t req);
    logic [7:0] len_byte;
    if (req.func == nfc_enc_pkg::FuncStart) begin
      len_byte = req.payload_len + 8'd2;
      frame_bytes_q.push_back(frame_byte(nfc_enc_pkg::PreambleByte, 1'b0, 1'b0));
      frame_bytes_q.push_back(frame_byte(nfc_enc_pkg::StartCode1, 1'b0, 1'b0));
      frame_bytes_q.push_back(frame_byte(nfc_enc_pkg::StartCode2, 1'b0, 1'b0));
      frame_bytes_q.push_back(frame_byte(len_byte, 1'b0, 1'b0));
      frame_bytes_q.push_back(frame_byte(8'h00 - len_byte, 1'b0, 1'b0));
      frame_bytes_q.push_back(frame_byte(nfc_enc_pkg::DirHostToCtrl, 1'b0, 1'b0));
      frame_bytes_q.push_back(frame_byte(req.cmd, 1'b0, 1'b0));
      enc_sum  = nfc_enc_pkg::DirHostToCtrl + req.cmd;
      enc_left = req.payload_len;
      enc_open = 1'b1;
      if (req.payload_len == 8'd0) close_predicted_frame();
    end else if (!enc_open) begin
      frame_bytes_q.push_back(frame_byte(nfc_enc_pkg::ErrorByte, 1'b1, 1'b1));
    end else begin
      frame_bytes_q.push_back(frame_byte(req.data_byte, 1'b0, 1'b0));
      enc_sum  = enc_sum + req.data_byte;
      enc_left = enc_left - 8'd1;
      if (enc_left == 8'd0) close_predicted_frame();
    end
  endtask

  function automatic nfc_enc_pkg::in_item_t start_req(logic [7:0] cmd, logic [7:0] len);
    nfc_enc_pkg::in_item_t r;
    r.func        = nfc_enc_pkg::FuncStart;
    r.cmd         = cmd;
    r.payload_len = len;
    r.data_byte   = 8'($urandom);
    return r;
  endfunction

  function automatic nfc_enc_pkg::in_item_t payload_req(logic [7:0] data);
    nfc_enc_pkg::in_item_t r;
    r.func        = nfc_enc_pkg::FuncPayload;
    r.cmd         = 8'($urandom);
    r.payload_len = 8'($urandom);
    r.data_byte   = data;
    return r;
  endfunction

  // called at a rising edge, returns at the edge where the request is taken
  task automatic send_request(input nfc_enc_pkg::in_item_t req);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_frame_bytes(req);
    requests_sent++;
  endtask

  task automatic wait_all_bytes_out();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int unsigned len);
    send_request(start_req(cmd, 8'(len)));
    for (int unsigned k = 0; k < len; k++) send_request(payload_req(8'($urandom)));
  endtask

  task automatic test_directed_cases();
    send_request(payload_req(8'hFF));
    send_request(start_req(8'h00, 8'd0));
    send_request(start_req(8'hFF, 8'd0));
    send_request(start_req(8'h5A, 8'd1));
    send_request(payload_req(8'hFF));
    send_request(start_req(8'hA5, 8'd2));
    send_request(payload_req(8'h00));
    send_request(payload_req(8'hFF));
    send_request(payload_req(8'h00));
    // abandoned frames
    send_request(start_req(8'h12, 8'd3));
    send_request(payload_req(8'h80));
    send_request(start_req(8'h34, 8'd253));
    send_request(payload_req(8'h7F));
    send_request(start_req(8'h56, 8'd254));
    send_request(payload_req(8'h01));
    send_request(start_req(8'hD4, 8'd1));
    send_request(payload_req(8'h2C));
    send_request(payload_req(8'hAA));
  endtask

  task automatic test_long_frame();
    send_frame(8'($urandom), 40);
    send_request(payload_req(8'($urandom)));
  endtask

  task automatic test_output_stall();
    rx_hold_req = 1'b1;
    send_frame(8'($urandom), 6);
    send_frame(8'($urandom), 0);
    send_frame(8'($urandom), 5);
  endtask

  task automatic test_drain_pause();
    send_frame(8'($urandom), 3);
    wait_all_bytes_out();
    send_frame(8'($urandom), 2);
  endtask

  task automatic send_random_frame();
    int unsigned len;
    int unsigned cut;
    if ($urandom_range(0, 4) == 0) begin
      send_request(nfc_enc_pkg::in_item_t'(InItemW'($urandom)));
      return;
    end
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    cut = len;
    if (len > 0 && $urandom_range(0, 7) == 0) cut = $urandom_range(0, len - 1);
    send_request(start_req(8'($urandom), 8'(len)));
    for (int unsigned k = 0; k < cut; k++) send_request(payload_req(8'($urandom)));
    if (cut == len && $urandom_range(0, 7) == 0) send_request(payload_req(8'($urandom)));
  endtask

  task automatic test_random_frames();
    int unsigned first;
    first = requests_sent;
    while (requests_sent - first < 50) send_random_frame();
  endtask

  task automatic test_back_to_back();
    int unsigned first;
    idle_en = 1'b0;
    first = requests_sent;
    while (requests_sent - first < 30) send_random_frame();
  endtask

  task automatic log_mismatch(input string what, input nfc_enc_pkg::out_item_t want,
                              input nfc_enc_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected byte %02h end %0b err %0b, got byte %02h end %0b err %0b",
               $realtime, what, want.out_byte, want.frame_end, want.error,
               got.out_byte, got.frame_end, got.error);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (frame_bytes_q.size() == 0) begin
        log_mismatch("unexpected byte", '0, out_item);
      end else begin
        want_byte = frame_bytes_q.pop_front();
        if (out_item.out_byte !== want_byte.out_byte ||
            out_item.frame_end !== want_byte.frame_end ||
            out_item.error !== want_byte.error)
          log_mismatch("byte mismatch", want_byte, out_item);
      end
    end
  end

  // receiver side
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_long_frame();
    test_output_stall();
    test_drain_pause();
    test_random_frames();
    test_back_to_back();
    wait_all_bytes_out();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && frame_bytes_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: nfc_host_frame_encoder_core.f
src/nfc_enc_pkg.sv
src/nfc_enc_front.sv
src/nfc_enc_queue.sv
src/nfc_enc_back.sv
src/nfc_host_frame_encoder_core.sv
verif/nfc_host_frame_encoder_core_tb.sv
